/* hw/rtl/mau_pkg.sv */
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants for the modular arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mau_pkg;
  localparam int ModW = 31;
  localparam int OpW  = 64;
  localparam logic [ModW-1:0] ModReset = 31'd1000000007;

  typedef enum logic [2:0] {
    CMD_RED = 3'd0, CMD_ADD = 3'd1, CMD_SUB = 3'd2, CMD_MUL = 3'd3,
    CMD_DIV = 3'd4, CMD_NEG = 3'd5, CMD_INV = 3'd6, CMD_POW = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [2:0]     cmd;
    logic [OpW-1:0] operand_a;
    logic [OpW-1:0] operand_b;
    logic [OpW-1:0] exponent;
  } in_item_t;
endpackage
`default_nettype wire

/* hw/rtl/mau_if.sv */
// ----------------------------------------------------------------------------
// mau_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface mau_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hw/rtl/modular_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_top
// Modular arithmetic unit: reduce, add, sub, mul, div, negate, inverse, power.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in       in   cmd, operand_a, operand_b, exponent (in_item_t)
// out      out  result [30:0]
// cfg      in   cfg_we, cfg_wdata [30:0] modulus
// Bit-serial engine: reduction and modmul take one bit per cycle; reduction
// and division share a shift/subtract unit, modmul uses a double-and-add
// step. Power is square-and-multiply over modmul; inverse uses bit-serial
// division for each Euclid step. One item at a time.
// Synchronous active-low reset; output register holds until transferred.
// ----------------------------------------------------------------------------
`default_nettype none
module modular_arithmetic_unit_top
  import mau_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  mau_if.sink                  in_ch,
  mau_if.source                out_ch,
  input  wire logic            cfg_we,
  input  wire logic [ModW-1:0] cfg_wdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_OP, S_MUL, S_PW, S_IV, S_DV, S_IVE, S_OUT
  } st_t;

  st_t st_r;
  logic [ModW-1:0] mod_r, m;
  logic [2:0] cmd_r;
  logic [OpW-1:0] opb_r, exp_r;
  logic [ModW-1:0] a_r, res_r;
  // serial reducer / divider
  logic [OpW-1:0] dq_r;   // dividend shifting out, quotient shifting in
  logic [OpW:0] rem_r;
  logic [6:0] cnt_r;
  logic neg_r;
  // modmul
  logic [ModW-1:0] mx_r, my_r, macc_r;
  logic [1:0] mret_r;      // 0 = op result, 1 = pow acc, 2 = pow sq
  // power
  logic [ModW-1:0] acc_r, sq_r;
  // euclid
  logic signed [OpW-1:0] eb_r, eu_r, ev_r, qv_r;

  assign m = (mod_r == '0) ? ModW'(1) : mod_r;
  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.payload = res_r;

  logic [OpW:0] rsh;
  logic [OpW:0] msub;
  assign rsh = {rem_r[OpW-1:0], dq_r[OpW-1]};
  assign msub = {{(OpW+1-ModW){1'b0}}, m};

  logic [ModW:0] md, madd;
  logic [ModW+1:0] mdbl;
  assign mdbl = {1'b0, macc_r, 1'b0};
  assign md = (mdbl >= {2'b0, m}) ? (mdbl[ModW:0] - {1'b0, m}) : mdbl[ModW:0];
  assign madd = my_r[ModW-1] ? (md + {1'b0, mx_r}) : md;

  logic [ModW-1:0] rfin;
  assign rfin = (rem_r[ModW-1:0] == '0 || !neg_r) ? rem_r[ModW-1:0]
                : m - rem_r[ModW-1:0];

  function automatic logic [ModW-1:0] addm(logic [ModW-1:0] x, logic [ModW-1:0] y,
                                           logic [ModW-1:0] mm);
    logic [ModW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, mm}) s = s - {1'b0, mm};
    return s[ModW-1:0];
  endfunction

  logic signed [OpW-1:0] nu;
  assign nu = eu_r - qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      mod_r <= ModReset;
    end else begin
      if (cfg_we) mod_r <= cfg_wdata;
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          cmd_r <= in_ch.payload.cmd;
          opb_r <= in_ch.payload.operand_b;
          exp_r <= in_ch.payload.exponent;
          neg_r <= in_ch.payload.operand_a[OpW-1];
          dq_r <= in_ch.payload.operand_a[OpW-1] ? -in_ch.payload.operand_a
                                                 : in_ch.payload.operand_a;
          rem_r <= '0;
          cnt_r <= '0;
          st_r <= S_RA;
        end
        S_RA, S_RB, S_DV: begin
          rem_r <= (rsh >= msub && st_r != S_DV) ? rsh - msub :
                   (st_r == S_DV && rsh >= {1'b0, eb_r}) ? rsh - {1'b0, eb_r} : rsh;
          dq_r <= {dq_r[OpW-2:0], (st_r == S_DV) ? (rsh >= {1'b0, eb_r}) : 1'b0};
          if (st_r == S_DV) qv_r <= (qv_r <<< 1) + ((rsh >= {1'b0, eb_r}) ? ev_r : 64'sd0);
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            cnt_r <= '0;
            if (st_r == S_RA) begin
              st_r <= S_RB;
              neg_r <= opb_r[OpW-1];
              dq_r <= opb_r[OpW-1] ? -opb_r : opb_r;
              rem_r <= '0;
            end else if (st_r == S_RB) st_r <= S_OP;
            else st_r <= S_IVE;
          end
          if (st_r == S_RA && cnt_r == 7'd63) a_r <= (rsh >= msub) ?
            ((neg_r && (rsh - msub) != 0) ? m - ModW'(rsh - msub) : ModW'(rsh - msub)) :
            ((neg_r && rsh != 0) ? m - ModW'(rsh) : ModW'(rsh));
        end
        S_OP: begin
          st_r <= S_OUT;
          mret_r <= 2'd0;
          cnt_r <= '0;
          macc_r <= '0;
          case (cmd_t'(cmd_r))
            CMD_RED: res_r <= a_r;
            CMD_ADD: res_r <= addm(a_r, rfin, m);
            CMD_SUB: res_r <= addm(a_r, (rfin == '0) ? '0 : m - rfin, m);
            CMD_NEG: res_r <= (a_r == '0) ? '0 : m - a_r;
            CMD_MUL: begin mx_r <= a_r; my_r <= rfin; st_r <= S_MUL; end
            CMD_INV, CMD_DIV: begin
              eb_r <= OpW'(m); eu_r <= 64'sd1; ev_r <= '0;
              qv_r <= '0;
              dq_r <= OpW'((cmd_r == CMD_INV) ? a_r : rfin);
              rem_r <= '0;
              st_r <= S_DV;
            end
            default: begin
              acc_r <= (m == ModW'(1)) ? '0 : ModW'(1);
              sq_r <= a_r;
              if (exp_r[OpW-1] || exp_r == '0) begin
                res_r <= (m == ModW'(1)) ? '0 : ModW'(1);
              end else st_r <= S_PW;
            end
          endcase
        end
        S_IVE: begin
          // dq_r = quotient, rem_r = new a
          eb_r <= $signed(rem_r[OpW-1:0]);
          eu_r <= ev_r; ev_r <= nu;
          if (rem_r[OpW-1:0] == '0) begin
            // final u is ev_r (new u); reduce signed
            neg_r <= ev_r[OpW-1];
            dq_r <= ev_r[OpW-1] ? -ev_r : ev_r;
            rem_r <= '0; cnt_r <= '0;
            st_r <= S_RB;
            cmd_r <= (cmd_r == CMD_INV) ? CMD_RED : CMD_MUL;
            opb_r <= ev_r;
            a_r <= a_r;
          end else begin
            dq_r <= eb_r; rem_r <= '0; cnt_r <= '0;
            qv_r <= '0;
            st_r <= S_DV;
          end
          if (rem_r[OpW-1:0] == '0 && cmd_r == CMD_INV) begin
            st_r <= S_RA;
            neg_r <= ev_r[OpW-1];
            dq_r <= ev_r[OpW-1] ? -ev_r : ev_r;
            opb_r <= '0;
          end
        end
        S_MUL: begin
          macc_r <= (madd >= {1'b0, m}) ? ModW'(madd - {1'b0, m}) : ModW'(madd);
          my_r <= {my_r[ModW-2:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(ModW-1)) begin
            cnt_r <= '0;
            case (mret_r)
              2'd0: begin res_r <= (madd >= {1'b0, m}) ? ModW'(madd - {1'b0, m})
                                                       : ModW'(madd); st_r <= S_OUT; end
              2'd1: begin acc_r <= (madd >= {1'b0, m}) ? ModW'(madd - {1'b0, m})
                                                       : ModW'(madd); st_r <= S_PW; end
              default: begin
                sq_r <= (madd >= {1'b0, m}) ? ModW'(madd - {1'b0, m}) : ModW'(madd);
                exp_r <= {1'b0, exp_r[OpW-1:1]};
                st_r <= S_PW;
              end
            endcase
          end
        end
        S_PW: begin
          macc_r <= '0; cnt_r <= '0; st_r <= S_MUL;
          if (exp_r == '0) begin res_r <= acc_r; st_r <= S_OUT; end
          else if (exp_r[0] && mret_r != 2'd1) begin
            mret_r <= 2'd1; mx_r <= acc_r; my_r <= sq_r;
          end else begin
            mret_r <= 2'd2; mx_r <= sq_r; my_r <= sq_r;
          end
        end
        S_OUT: if (out_ch.ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* verif/tb_modular_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// tb_modular_arithmetic_unit_top
// Self-checking bench for the modular arithmetic unit. A queue of operations
// feeds a clocked driver; a clocked monitor compares every result transfer
// with a modular arithmetic predictor, across several moduli and idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_modular_arithmetic_unit_top;
  import mau_pkg::*;

  localparam longint unsigned CycleLimit = 40000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ModW-1:0] cfg_wdata;

  mau_if #(.payload_t(in_item_t)) in_ch ();
  mau_if #(.payload_t(logic [ModW-1:0])) out_ch ();

  modular_arithmetic_unit_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  in_item_t op_queue[$];
  logic [ModW-1:0] result_queue[$];
  longint unsigned modulus_q;
  int idle_mode;
  int errors;
  int ops_sent;
  int results_seen;
  longint unsigned cycles;

  // --- modular arithmetic predictor -----------------------------------------
  function automatic longint unsigned reduce_op(logic [63:0] raw, longint unsigned m);
    longint unsigned mag;
    if (!raw[63]) return raw % m;
    mag = (64'd0 - raw) % m;
    return (mag == 0) ? 0 : m - mag;
  endfunction

  function automatic longint unsigned inverse_of(longint unsigned x, longint unsigned m);
    longint a, b, u, v, q, na, nu;
    a = x; b = m; u = 1; v = 0;
    while (b > 0) begin
      q = a / b;
      na = a - q * b;
      nu = u - q * v;
      a = b; b = na; u = v; v = nu;
    end
    return reduce_op(u, m);
  endfunction

  function automatic longint unsigned power_of(longint unsigned base, logic [63:0] e_raw,
                                              longint unsigned m);
    longint unsigned acc, sq;
    logic [63:0] e;
    acc = 1 % m;
    sq = base;
    if (e_raw[63] || e_raw == 0) return acc;
    e = e_raw;
    while (e > 0) begin
      if (e[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [ModW-1:0] predict_result(in_item_t it);
    longint unsigned m, a, b, r;
    m = (modulus_q == 0) ? 1 : modulus_q;
    a = reduce_op(it.operand_a, m);
    b = reduce_op(it.operand_b, m);
    case (cmd_t'(it.cmd))
      CMD_RED: r = a;
      CMD_ADD: begin
        r = a + b;
        if (r >= m) r = r - m;
      end
      CMD_SUB: r = (a < b) ? a + m - b : a - b;
      CMD_MUL: r = (a * b) % m;
      CMD_DIV: r = (a * inverse_of(b, m)) % m;
      CMD_NEG: r = (a == 0) ? 0 : m - a;
      CMD_INV: r = inverse_of(a, m);
      default: r = power_of(a, it.exponent, m);
    endcase
    return r[ModW-1:0];
  endfunction

  // --- stimulus helpers -------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'($urandom_range(0, 20));
      3: return -64'($urandom_range(0, 20));
      4: return 64'(modulus_q) + 64'($urandom_range(0, 4)) - 64'd2;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return rand64();
      1: return -64'($urandom_range(0, 50));
      2: return 64'd0;
      default: return 64'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic add_op(cmd_t c, logic [63:0] a, logic [63:0] b, logic [63:0] e);
    in_item_t it;
    it.cmd = c;
    it.operand_a = a;
    it.operand_b = b;
    it.exponent = e;
    op_queue.push_back(it);
  endtask

  task automatic add_random_ops(int n);
    for (int i = 0; i < n; i++)
      add_op(cmd_t'($urandom_range(0, 7)), pick_operand(), pick_operand(), pick_exponent());
  endtask

  task automatic drain();
    while (op_queue.size() != 0 || result_queue.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_modulus(logic [ModW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_q = v;
  endtask

  function automatic bit stall(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // --- clock ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --- driver -----------------------------------------------------------------
  always @(posedge clk) begin
    bit moved;
    bit idle;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      moved = in_ch.valid && in_ch.ready;
      if (moved) begin
        result_queue.push_back(predict_result(in_ch.payload));
        void'(op_queue.pop_front());
        ops_sent++;
      end
      idle = (idle_mode == 1) ? stall(56) : (idle_mode == 3) ? stall(19) : 1'b0;
      if (op_queue.size() != 0 && ((in_ch.valid && !moved) || !idle)) begin
        in_ch.valid <= 1'b1;
        in_ch.payload <= op_queue[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --- monitor ----------------------------------------------------------------
  always @(posedge clk) begin
    logic [ModW-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (result_queue.size() == 0) begin
          $display("%0t: result %0d with nothing expected", $time, out_ch.payload);
          errors++;
        end else begin
          want = result_queue.pop_front();
          if (out_ch.payload !== want) begin
            $display("%0t: result mismatch, expected %0d, actual %0d",
                     $time, want, out_ch.payload);
            errors++;
          end
        end
      end
      out_ch.ready <= (idle_mode == 2) ? !stall(56) : (idle_mode == 3) ? !stall(19) : 1'b1;
    end
  end

  // --- watchdog ---------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, result_queue.size());
      $display("tb_modular_arithmetic_unit_top: done, errors");
      $finish;
    end
  end

  // --- sequence ---------------------------------------------------------------
  initial begin
    logic [ModW-1:0] moduli[5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    modulus_q = ModReset;
    idle_mode = 0;
    errors = 0;
    ops_sent = 0;
    results_seen = 0;
    cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, inverse of zero, non-positive powers
    add_op(CMD_RED, 64'h8000_0000_0000_0000, 64'd0, 64'd0);
    add_op(CMD_RED, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'd0);
    add_op(CMD_RED, -64'd1, 64'd0, 64'd0);
    add_op(CMD_ADD, -64'd1, -64'd1, 64'd0);
    add_op(CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd0);
    add_op(CMD_SUB, 64'd0, 64'd1, 64'd0);
    add_op(CMD_SUB, 64'd5, 64'd3, 64'd0);
    add_op(CMD_MUL, -64'd1, -64'd1, 64'd0);
    add_op(CMD_MUL, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    add_op(CMD_DIV, 64'd10, 64'd3, 64'd0);
    add_op(CMD_DIV, 64'd10, 64'd0, 64'd0);
    add_op(CMD_NEG, 64'd0, 64'd0, 64'd0);
    add_op(CMD_NEG, 64'd1, 64'd0, 64'd0);
    add_op(CMD_INV, 64'd0, 64'd0, 64'd0);
    add_op(CMD_INV, 64'd2, 64'd0, 64'd0);
    add_op(CMD_INV, -64'd1, 64'd0, 64'd0);
    add_op(CMD_POW, 64'd3, 64'd0, 64'd0);
    add_op(CMD_POW, 64'd3, 64'd0, -64'd1);
    add_op(CMD_POW, 64'd3, 64'd0, 64'h8000_0000_0000_0000);
    add_op(CMD_POW, 64'd2, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    add_op(CMD_POW, -64'd2, 64'd0, 64'd62);
    add_random_ops(150);
    drain();

    moduli = '{31'd1, 31'd0, 31'h7FFF_FFFF, 31'd12, 31'($urandom_range(2, 100000))};
    for (int p = 0; p < 5; p++) begin
      idle_mode = (p + 1) % 4;
      set_modulus(moduli[p]);
      add_random_ops(90);
      drain();
      add_random_ops(90);
      drain();
    end

    repeat (100) @(posedge clk);
    errors += result_queue.size();
    $display("Covered %0d operations and %0d results over six moduli (reset, 1, 0, max,",
             ops_sent, results_seen);
    $display("composite, random) with free-running, sender, receiver and mixed stalls.");
    if (errors == 0) begin
      $display("tb_modular_arithmetic_unit_top: done, clean");
    end else begin
      $display("tb_modular_arithmetic_unit_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* modular_arithmetic_unit_top.f */
hw/rtl/mau_pkg.sv
hw/rtl/mau_if.sv
hw/rtl/modular_arithmetic_unit_top.sv
verif/tb_modular_arithmetic_unit_top.sv
